>>> hdl/olide_pkg.sv
// ----------------------------------------------------------------------------
// olide_pkg
// Shared codes and types for the ordered list engine: operation and status
// codes, and the per-cell control word.
// ----------------------------------------------------------------------------
package olide_pkg;

  typedef logic [1:0] op_t;
  typedef logic [1:0] status_t;

  localparam op_t OP_TAIL   = 2'd0;
  localparam op_t OP_HEAD   = 2'd1;
  localparam op_t OP_DELETE = 2'd2;
  localparam op_t OP_LIST   = 2'd3;

  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_EMPTY     = 2'd3;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  typedef enum logic [2:0] {
    CMD_HOLD = 3'd0,
    CMD_LOAD = 3'd1,
    CMD_PREV = 3'd2,
    CMD_NEXT = 3'd3,
    CMD_DEL  = 3'd4
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      occupied;
  } cell_ctl_t;

endpackage

>>> hdl/olide_if.sv
// ----------------------------------------------------------------------------
// olide_req_if / olide_rsp_if
// Valid/ready channels for requests into and results out of the list engine.
// ----------------------------------------------------------------------------
interface olide_req_if;
  logic                                   valid;
  logic                                   ready;
  olide_pkg::op_t                         operation;
  logic signed [olide_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface olide_rsp_if;
  logic                                   valid;
  logic                                   ready;
  olide_pkg::status_t                     status;
  logic signed [olide_pkg::VALUE_W-1:0]   entry_value;
  logic                                   last;
  logic [olide_pkg::COUNT_W-1:0]          entry_count;

  modport source (output valid, output status, output entry_value, output last,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input entry_value, input last,
                  input entry_count, output ready);
endinterface

>>> hdl/olide_cell.sv
// ----------------------------------------------------------------------------
// olide_cell
// One list position: holds a value, compares it with the delete key and
// passes the first-match flag on to the next position.
// ----------------------------------------------------------------------------
module olide_cell (
  input  logic                                 clk,
  input  olide_pkg::cell_ctl_t                 ctl,
  input  logic signed [olide_pkg::VALUE_W-1:0] din,
  input  logic signed [olide_pkg::VALUE_W-1:0] prev_val,
  input  logic signed [olide_pkg::VALUE_W-1:0] next_val,
  input  logic signed [olide_pkg::VALUE_W-1:0] key,
  input  logic                                 hit_in,
  output logic                                 hit_out,
  output logic signed [olide_pkg::VALUE_W-1:0] val
);

  logic match;

  assign match   = ctl.occupied && (val == key);
  assign hit_out = hit_in || match;

  always_ff @(posedge clk) begin
    unique case (ctl.cmd)
      olide_pkg::CMD_HOLD: val <= val;
      olide_pkg::CMD_LOAD: val <= din;
      olide_pkg::CMD_PREV: val <= prev_val;
      olide_pkg::CMD_NEXT: val <= next_val;
      olide_pkg::CMD_DEL: begin
        if (hit_out) val <= next_val;
      end
      default: val <= val;
    endcase
  end

endmodule

>>> hdl/ordered_list_insert_delete_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete_engine
// Ordered list of up to CAPACITY signed values kept in a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   req carries an operation and a value: append at tail, prepend at head,
//   delete first match from head, or list out. rsp returns results with
//   status, entry_value, last and entry_count.
//   Append, prepend and delete finish in the cycle the request is taken;
//   the single result is registered and shows in the next cycle. One
//   request per cycle while rsp is drained.
//   List out of an empty list gives a single ST_EMPTY result. Otherwise
//   the engine enters S_LIST and registers one result per entry, one per
//   cycle while rsp drains. The cells rotate one position per emitted
//   result, so the head cell always shows the next entry and the list is
//   back in order after the last one. req is held off during the listing.
//   A stalled rsp holds its result; req.ready drops until the result
//   register frees up, and the rotation stalls with it.
//   Reset empties the list and drops any pending result. No clearing pass.
// ----------------------------------------------------------------------------
module ordered_list_insert_delete_engine #(
  parameter int CAPACITY = 16
) (
  input  logic          clk,
  input  logic          rst,
  olide_req_if.sink     req,
  olide_rsp_if.source   rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VW    = olide_pkg::VALUE_W;
  localparam int CW    = olide_pkg::COUNT_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LIST = 2'b10
  } state_t;

  state_t                state;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [CNT_W-1:0]      remain;
  logic                  full;
  logic                  out_free;
  logic                  accept;
  logic                  emit;
  logic                  found;
  logic [CNT_W+CW-1:0]   cnt_ext;
  logic [CNT_W+CW-1:0]   cnt_now_ext;

  logic signed [VW-1:0]  vals     [CAPACITY];
  logic signed [VW-1:0]  prev_val [CAPACITY];
  logic signed [VW-1:0]  next_val [CAPACITY];
  olide_pkg::cell_ctl_t  ctl      [CAPACITY];
  logic [CAPACITY:0]     hit;

  assign full     = (count == CNT_W'(CAPACITY));
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept   = req.valid && req.ready;
  assign emit     = (state == S_LIST) && out_free;
  assign hit[0]   = 1'b0;
  assign found    = hit[CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign prev_val[i] = req.value;
    end else begin : g_mid
      assign prev_val[i] = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_end
      assign next_val[i] = vals[0];
    end else begin : g_inner
      assign next_val[i] = (CNT_W'(i + 1) == count) ? vals[0] : vals[i+1];
    end

    always_comb begin
      ctl[i].occupied = (CNT_W'(i) < count);
      ctl[i].cmd      = olide_pkg::CMD_HOLD;
      if (emit) begin
        ctl[i].cmd = olide_pkg::CMD_NEXT;
      end else if (accept) begin
        unique case (req.operation)
          olide_pkg::OP_TAIL: begin
            if (!full && CNT_W'(i) == count) ctl[i].cmd = olide_pkg::CMD_LOAD;
          end
          olide_pkg::OP_HEAD: begin
            if (!full) ctl[i].cmd = (i == 0) ? olide_pkg::CMD_LOAD : olide_pkg::CMD_PREV;
          end
          olide_pkg::OP_DELETE: ctl[i].cmd = olide_pkg::CMD_DEL;
          olide_pkg::OP_LIST:   ctl[i].cmd = olide_pkg::CMD_HOLD;
          default:              ctl[i].cmd = olide_pkg::CMD_HOLD;
        endcase
      end
    end

    olide_cell u_cell (
      .clk      (clk),
      .ctl      (ctl[i]),
      .din      (req.value),
      .prev_val (prev_val[i]),
      .next_val (next_val[i]),
      .key      (req.value),
      .hit_in   (hit[i]),
      .hit_out  (hit[i+1]),
      .val      (vals[i])
    );
  end

  always_comb begin
    count_next = count;
    if (accept) begin
      unique case (req.operation)
        olide_pkg::OP_TAIL,
        olide_pkg::OP_HEAD:   if (!full) count_next = count + CNT_W'(1);
        olide_pkg::OP_DELETE: if (found) count_next = count - CNT_W'(1);
        olide_pkg::OP_LIST:   count_next = count;
        default:              count_next = count;
      endcase
    end
  end

  assign cnt_ext     = {{CW{1'b0}}, count_next};
  assign cnt_now_ext = {{CW{1'b0}}, count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      count <= count_next;
      if (emit) begin
        rsp.valid       <= 1'b1;
        rsp.status      <= olide_pkg::ST_OK;
        rsp.entry_value <= vals[0];
        rsp.last        <= (remain == CNT_W'(1));
        rsp.entry_count <= cnt_now_ext[CW-1:0];
        remain          <= remain - CNT_W'(1);
        if (remain == CNT_W'(1)) state <= S_IDLE;
      end else if (accept) begin
        if (req.operation == olide_pkg::OP_LIST && count != '0) begin
          state     <= S_LIST;
          remain    <= count;
          rsp.valid <= 1'b0;
        end else begin
          rsp.valid       <= 1'b1;
          rsp.entry_value <= '0;
          rsp.last        <= 1'b1;
          rsp.entry_count <= cnt_ext[CW-1:0];
          unique case (req.operation)
            olide_pkg::OP_TAIL,
            olide_pkg::OP_HEAD:   rsp.status <= full ? olide_pkg::ST_FULL : olide_pkg::ST_OK;
            olide_pkg::OP_DELETE: rsp.status <= found ? olide_pkg::ST_OK
                                                      : olide_pkg::ST_NOT_FOUND;
            olide_pkg::OP_LIST:   rsp.status <= olide_pkg::ST_EMPTY;
            default:              rsp.status <= olide_pkg::ST_OK;
          endcase
        end
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

endmodule

>>> hdl/olide_checker.sv
// ----------------------------------------------------------------------------
// olide_checker
// Port-level checks on the list engine's result channel.
// ----------------------------------------------------------------------------
module olide_checker #(
  parameter int CAPACITY = 16
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 rsp_valid,
  input logic                                 rsp_ready,
  input olide_pkg::status_t                   rsp_status,
  input logic signed [olide_pkg::VALUE_W-1:0] rsp_entry_value,
  input logic                                 rsp_last,
  input logic [olide_pkg::COUNT_W-1:0]        rsp_entry_count
);

  localparam int CW = olide_pkg::COUNT_W;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (CAPACITY < (1 << CW)) |-> (32'(rsp_entry_count) <= 32'(CAPACITY)))
    else $error("entry count above capacity");

  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status != olide_pkg::ST_OK |-> rsp_last && rsp_entry_value == '0)
    else $error("error result not single or carries a value");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == olide_pkg::ST_EMPTY |-> rsp_entry_count == '0)
    else $error("empty listing with nonzero count");

endmodule

bind ordered_list_insert_delete_engine olide_checker #(.CAPACITY(CAPACITY)) u_olide_checker (
  .clk             (clk),
  .rst             (rst),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_status      (rsp.status),
  .rsp_entry_value (rsp.entry_value),
  .rsp_last        (rsp.last),
  .rsp_entry_count (rsp.entry_count)
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ordered list engine. A queue of requests
// (append, prepend, delete, list out) feeds a valid/ready driver. A mirror of
// the list predicts every result, and a monitor compares each returned
// result field by field against the oldest prediction. Both channels idle
// at random, except for one calm stretch.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int LIST_DEPTH  = 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE   = 6;
  localparam int VW          = olide_pkg::VALUE_W;
  localparam int CW          = olide_pkg::COUNT_W;

  typedef struct {
    olide_pkg::op_t       op;
    logic signed [VW-1:0] val;
  } list_req_t;

  typedef struct {
    olide_pkg::status_t   status;
    logic signed [VW-1:0] entry_value;
    logic                 last;
    logic [CW-1:0]        entry_count;
  } list_rsp_t;

  typedef enum {GROW, SHRINK, MIXED} phase_kind_t;

  logic clk;
  logic rst;
  logic calm;
  logic req_fire;

  olide_req_if req ();
  olide_rsp_if rsp ();

  ordered_list_insert_delete_engine #(.CAPACITY(LIST_DEPTH)) uut (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source)
  );

  list_req_t            request_q[$];
  list_rsp_t            pending_results[$];
  logic signed [VW-1:0] mirror_entries[$];
  logic signed [VW-1:0] key_pool[POOL_SIZE];

  int cycle_count    = 0;
  int accepted_count = 0;
  int checked_count  = 0;
  int error_count    = 0;
  int full_rejects   = 0;
  int delete_misses  = 0;
  int empty_listings = 0;
  int longest_list   = 0;

  assign calm = (accepted_count >= 100) && (accepted_count < 160);

  function automatic list_rsp_t make_rsp(olide_pkg::status_t st,
                                         logic signed [VW-1:0] ev, logic lst);
    list_rsp_t r;
    r.status      = st;
    r.entry_value = ev;
    r.last        = lst;
    r.entry_count = CW'(mirror_entries.size());
    return r;
  endfunction

  function automatic void predict_list_op(olide_pkg::op_t op, logic signed [VW-1:0] val);
    int hit;
    hit = -1;
    case (op)
      olide_pkg::OP_TAIL, olide_pkg::OP_HEAD: begin
        if (mirror_entries.size() >= LIST_DEPTH) begin
          full_rejects++;
          pending_results.push_back(make_rsp(olide_pkg::ST_FULL, '0, 1'b1));
        end else begin
          if (op == olide_pkg::OP_TAIL) mirror_entries.push_back(val);
          else mirror_entries.push_front(val);
          if (mirror_entries.size() > longest_list) longest_list = mirror_entries.size();
          pending_results.push_back(make_rsp(olide_pkg::ST_OK, '0, 1'b1));
        end
      end
      olide_pkg::OP_DELETE: begin
        for (int i = 0; i < mirror_entries.size(); i++) begin
          if (hit < 0 && mirror_entries[i] == val) hit = i;
        end
        if (hit < 0) begin
          delete_misses++;
          pending_results.push_back(make_rsp(olide_pkg::ST_NOT_FOUND, '0, 1'b1));
        end else begin
          mirror_entries.delete(hit);
          pending_results.push_back(make_rsp(olide_pkg::ST_OK, '0, 1'b1));
        end
      end
      default: begin
        if (mirror_entries.size() == 0) begin
          empty_listings++;
          pending_results.push_back(make_rsp(olide_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < mirror_entries.size(); i++) begin
            pending_results.push_back(make_rsp(olide_pkg::ST_OK, mirror_entries[i],
                                               i == mirror_entries.size() - 1));
          end
        end
      end
    endcase
  endfunction

  function automatic logic signed [VW-1:0] pick_value();
    if ($urandom_range(99) < 70) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic void add_req(olide_pkg::op_t op, logic signed [VW-1:0] val);
    list_req_t r;
    r.op  = op;
    r.val = val;
    request_q.push_back(r);
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // driver: advance to the next request only after a handshake
  always @(negedge clk) begin
    list_req_t nxt;
    if (rst) begin
      req.valid     <= 1'b0;
      req.operation <= olide_pkg::OP_TAIL;
      req.value     <= '0;
      rsp.ready     <= 1'b1;
    end else begin
      rsp.ready <= calm || ($urandom_range(99) >= 21);
      if (!req.valid || req_fire) begin
        if (request_q.size() != 0 && (calm || $urandom_range(99) >= 21)) begin
          nxt = request_q.pop_front();
          req.valid     <= 1'b1;
          req.operation <= nxt.op;
          req.value     <= nxt.val;
        end else begin
          req.valid <= 1'b0;
        end
      end
    end
  end

  // predictor and monitor
  always @(posedge clk) begin
    list_rsp_t want;
    cycle_count <= cycle_count + 1;
    req_fire    <= !rst && req.valid && req.ready;
    if (!rst) begin
      if (req.valid && req.ready) begin
        accepted_count++;
        predict_list_op(req.operation, req.value);
      end
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          $error("unexpected result: status %0d entry_value %0d last %0b entry_count %0d",
                 rsp.status, rsp.entry_value, rsp.last, rsp.entry_count);
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (rsp.status !== want.status) begin
            error_count++;
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
          end
          if (rsp.entry_value !== want.entry_value) begin
            error_count++;
            $error("entry_value: expected %0d, actual %0d", want.entry_value,
                   rsp.entry_value);
          end
          if (rsp.last !== want.last) begin
            error_count++;
            $error("last: expected %0b, actual %0b", want.last, rsp.last);
          end
          if (rsp.entry_count !== want.entry_count) begin
            error_count++;
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   rsp.entry_count);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    phase_kind_t kind;
    int          r;
    key_pool[0] = 32'sh7fffffff;
    key_pool[1] = 32'sh80000000;
    key_pool[2] = 0;
    key_pool[3] = -1;
    key_pool[4] = $urandom;
    key_pool[5] = $urandom;

    add_req(olide_pkg::OP_LIST,   0);
    add_req(olide_pkg::OP_DELETE, 0);
    add_req(olide_pkg::OP_TAIL,   32'sh7fffffff);
    add_req(olide_pkg::OP_HEAD,   32'sh80000000);
    add_req(olide_pkg::OP_TAIL,   0);
    add_req(olide_pkg::OP_TAIL,   -1);
    add_req(olide_pkg::OP_HEAD,   5);
    add_req(olide_pkg::OP_TAIL,   5);
    add_req(olide_pkg::OP_LIST,   0);
    add_req(olide_pkg::OP_DELETE, 5);
    add_req(olide_pkg::OP_DELETE, 1234);
    add_req(olide_pkg::OP_DELETE, -1);
    add_req(olide_pkg::OP_DELETE, 32'sh80000000);
    add_req(olide_pkg::OP_LIST,   -1);
    add_req(olide_pkg::OP_DELETE, 5);
    add_req(olide_pkg::OP_DELETE, 32'sh7fffffff);
    add_req(olide_pkg::OP_DELETE, 0);
    add_req(olide_pkg::OP_LIST,   32'sh7fffffff);

    for (int p = 0; p < 8; p++) begin
      case ($urandom_range(2))
        0:       kind = SHRINK;
        1:       kind = MIXED;
        default: kind = GROW;
      endcase
      if (p == 0 || p == 4) kind = GROW;
      for (int n = 0; n < 23; n++) begin
        r = $urandom_range(99);
        if ((kind == GROW && r < 80) || (kind == SHRINK && r < 20) ||
            (kind == MIXED && r < 40))
          add_req($urandom_range(1) ? olide_pkg::OP_HEAD : olide_pkg::OP_TAIL,
                  pick_value());
        else if ((kind == GROW && r < 88) || (kind != GROW && r < 78))
          add_req(olide_pkg::OP_DELETE, pick_value());
        else
          add_req(olide_pkg::OP_LIST, $urandom);
      end
    end

    while (request_q.size() != 0 || req.valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d results from %0d requests; list reached %0d entries.",
             checked_count, accepted_count, longest_list);
    $display("Rejected full inserts %0d, missed deletes %0d, empty listings %0d.",
             full_rejects, delete_misses, empty_listings);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> ordered_list_insert_delete_engine.f
hdl/olide_pkg.sv
hdl/olide_if.sv
hdl/olide_cell.sv
hdl/ordered_list_insert_delete_engine.sv
hdl/olide_checker.sv
tb/tb_top.sv
